FILE: hdl/wds_pkg.sv
// Shared types and constants for the windowed duration statistics block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package wds_pkg;

    localparam int DEPTH_DEFAULT         = 64;
    localparam int DURATION_BITS_DEFAULT = 32;

    // Width and reset value of the window length register.
    localparam int              WIN_W        = 7;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_REPLACE,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear;
        logic append;
        logic fetch;
        logic replace;
        logic scan_start;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode_clear;
        logic full;
        logic scan_done;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: hdl/wds_ctrl.sv
// Sequencing state machine for the windowed duration statistics block.
// Depends on wds_pkg for the state type and the command and status structs.
`default_nettype none

module wds_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wds_pkg::t_dp_status i_status,
    output wds_pkg::t_dp_cmd    o_cmd
);
    import wds_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_PREP;
                end
            end
            ST_PREP: begin
                if (i_status.mode_clear) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_DONE;
                end else if (i_status.full) begin
                    o_cmd.fetch = 1'b1;
                    n_state     = ST_REPLACE;
                end else begin
                    o_cmd.append     = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_REPLACE: begin
                o_cmd.replace    = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/wds_datapath.sv
// Sample store, running sum, min/max scan, serial divider and result register.
// Depends on wds_pkg for the command and status structs and register width.
`default_nettype none

module wds_datapath #(
    parameter int DEPTH         = wds_pkg::DEPTH_DEFAULT,
    parameter int DURATION_BITS = wds_pkg::DURATION_BITS_DEFAULT,
    localparam int CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wds_pkg::WIN_W-1:0] i_cfg_data,
    input  logic                      i_mode,
    input  logic [DURATION_BITS-1:0]  i_duration,
    input  wds_pkg::t_dp_cmd          i_cmd,
    output wds_pkg::t_dp_status       o_status,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic                      o_has_samples,
    output logic [CNT_W-1:0]          o_sample_count,
    output logic [DURATION_BITS-1:0]  o_last_duration,
    output logic [DURATION_BITS-1:0]  o_mean_duration,
    output logic [DURATION_BITS-1:0]  o_min_duration,
    output logic [DURATION_BITS-1:0]  o_max_duration
);
    import wds_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = DURATION_BITS + $clog2(DEPTH);
    localparam int DIVC_W = $clog2(SUM_W + 1);
    localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    logic [DURATION_BITS-1:0] r_mem [DEPTH];
    logic [DURATION_BITS-1:0] r_rd_data;

    logic [WIN_W-1:0]         r_window;
    logic [CNT_W-1:0]         r_count;
    logic [ADDR_W-1:0]        r_pos;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_mode;
    logic [DURATION_BITS-1:0] r_dur;

    logic [CNT_W-1:0]         r_scan_idx;
    logic                     r_scan_pend;
    logic [DURATION_BITS-1:0] r_lo;
    logic [DURATION_BITS-1:0] r_hi;

    logic [SUM_W-1:0]         r_quot;
    logic [CNT_W-1:0]         r_rem;
    logic [DIVC_W-1:0]        r_div_cnt;

    logic [CMP_W-1:0]  win_ext;
    logic [CNT_W-1:0]  w_eff;
    logic [CNT_W-1:0]  pos_inc;
    logic [ADDR_W-1:0] pos_next;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W:0]    rem_sh;
    logic              rem_ge;
    logic [CNT_W:0]    rem_sub;

    // Effective window: zero acts as one, anything above the depth as the depth.
    always_comb begin
        win_ext = CMP_W'(r_window);
        if (r_window == '0) begin
            win_ext = CMP_W'(1);
        end
        if (win_ext > CMP_W'(DEPTH)) begin
            win_ext = CMP_W'(DEPTH);
        end
        w_eff = win_ext[CNT_W-1:0];
    end

    assign pos_inc  = CNT_W'(r_pos) + CNT_W'(1);
    assign pos_next = (pos_inc == w_eff) ? '0 : pos_inc[ADDR_W-1:0];

    assign rd_en   = i_cmd.fetch || (i_cmd.scan_step && (r_scan_idx != r_count));
    assign rd_addr = i_cmd.fetch ? pos_next : r_scan_idx[ADDR_W-1:0];
    assign wr_en   = i_cmd.append || i_cmd.replace;
    assign wr_addr = i_cmd.append ? r_count[ADDR_W-1:0] : r_pos;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_dur;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Restoring division step: one quotient bit a cycle.
    assign rem_sh  = {r_rem, r_quot[SUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_count});
    assign rem_sub = rem_sh - {1'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_dur  <= i_duration;
        end
        if (i_cmd.scan_start) begin
            r_lo <= '1;
            r_hi <= '0;
        end else if (r_scan_pend) begin
            if (r_rd_data < r_lo) begin
                r_lo <= r_rd_data;
            end
            if (r_rd_data > r_hi) begin
                r_hi <= r_rd_data;
            end
        end
        if (i_cmd.div_start) begin
            r_quot <= r_sum;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[SUM_W-2:0], rem_ge};
            r_rem  <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
        if (i_cmd.load_out) begin
            o_has_samples   <= (r_count != '0);
            o_sample_count  <= r_count;
            o_last_duration <= (r_count != '0) ? r_dur : '0;
            o_mean_duration <= (r_count != '0) ? r_quot[DURATION_BITS-1:0] : '0;
            o_min_duration  <= (r_count != '0) ? r_lo : '0;
            o_max_duration  <= (r_count != '0) ? r_hi : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_count     <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_scan_idx  <= '0;
            r_scan_pend <= 1'b0;
            r_div_cnt   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
                r_count  <= '0;
                r_pos    <= '0;
                r_sum    <= '0;
            end else if (i_cmd.clear) begin
                r_count <= '0;
                r_pos   <= '0;
                r_sum   <= '0;
            end else if (i_cmd.append) begin
                r_pos   <= r_count[ADDR_W-1:0];
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + SUM_W'(r_dur);
            end else if (i_cmd.fetch) begin
                r_pos <= pos_next;
            end else if (i_cmd.replace) begin
                r_sum <= r_sum - SUM_W'(r_rd_data) + SUM_W'(r_dur);
            end

            if (i_cmd.scan_start) begin
                r_scan_idx  <= '0;
                r_scan_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_scan_pend <= (r_scan_idx != r_count);
                if (r_scan_idx != r_count) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
            end else begin
                r_scan_pend <= 1'b0;
            end

            if (i_cmd.div_start) begin
                r_div_cnt <= DIVC_W'(SUM_W);
            end else if (i_cmd.div_step && (r_div_cnt != '0)) begin
                r_div_cnt <= r_div_cnt - DIVC_W'(1);
            end

            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.mode_clear = r_mode;
        o_status.full       = (r_count >= w_eff);
        o_status.scan_done  = (r_scan_idx == r_count) && !r_scan_pend;
        o_status.div_done   = (r_div_cnt == '0);
        o_status.out_free   = !o_out_valid || i_out_ready;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("stored count exceeds the store depth");

    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (CNT_W'(r_pos) < w_eff))
        else $error("write position lies outside the window");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_samples) |-> (o_sample_count == '0 &&
        o_mean_duration == '0 && o_min_duration == '0 && o_max_duration == '0))
        else $error("empty result carries non-zero statistics");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

FILE: hdl/windowed_duration_statistics.sv
// A record beat passes through prep, scan, divide and done, with a replace state after prep
// when it overwrites; its scan reads the store one entry a cycle over the single read port to
// find the minimum and maximum, and the mean divider gives one bit a cycle. A clear beat goes
// from prep straight to done. One beat is in work at a time; the next is taken while a result
// waits in the output register. Synchronous active-low reset empties the store, sets the
// window to 64 and drops the output valid; the sample memory is not cleared.
`default_nettype none

// Top level of the windowed duration statistics block.
// Instantiates wds_ctrl and wds_datapath and depends on wds_pkg.
//
// Each record beat either appends its sample to the ring store, while the store holds
// fewer samples than the effective window, or overwrites the oldest entry and corrects
// the running sum by the sample it displaces. The store is then read back one entry a
// cycle to find the minimum and maximum, and the running sum is divided by the count
// with a restoring divider to give the truncated mean. A clear beat, or any write of
// the window register, empties the store; the result of a clear beat is all zeros.
// The window register is only to be written while the block is idle.
module windowed_duration_statistics #(
    parameter int DEPTH         = wds_pkg::DEPTH_DEFAULT,
    parameter int DURATION_BITS = wds_pkg::DURATION_BITS_DEFAULT,
    localparam int CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Window length register.
    input  logic                      i_cfg_we,
    input  logic [wds_pkg::WIN_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic [DURATION_BITS-1:0]  i_duration,
    // Result channel.
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_has_samples,
    output logic [CNT_W-1:0]          o_sample_count,
    output logic [DURATION_BITS-1:0]  o_last_duration,
    output logic [DURATION_BITS-1:0]  o_mean_duration,
    output logic [DURATION_BITS-1:0]  o_min_duration,
    output logic [DURATION_BITS-1:0]  o_max_duration
);
    import wds_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The controller holds only the state register; every other stored value lives in the datapath.
    wds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    wds_datapath #(
        .DEPTH         (DEPTH),
        .DURATION_BITS (DURATION_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_duration      (i_duration),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_has_samples   (o_has_samples),
        .o_sample_count  (o_sample_count),
        .o_last_duration (o_last_duration),
        .o_mean_duration (o_mean_duration),
        .o_min_duration  (o_min_duration),
        .o_max_duration  (o_max_duration)
    );

endmodule

`default_nettype wire

FILE: sim/windowed_duration_statistics_tb.sv
// Self-checking testbench for windowed_duration_statistics: directed and random beats
// with a bit-accurate predictor of the window statistics. Depends on wds_pkg and the RTL.
`timescale 1ns / 1ps

module windowed_duration_statistics_tb;

    import wds_pkg::*;

    localparam int DEPTH       = 64;
    localparam int DUR_W       = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = DUR_W + $clog2(DEPTH);
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 120;
    localparam int MAX_PRINTS  = 40;

    // The mode bit of an input beat.
    typedef enum bit {
        OP_RECORD = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // One result beat, laid out as the block reports it.
    typedef struct packed {
        bit             has;
        bit [CNT_W-1:0] count;
        bit [DUR_W-1:0] last;
        bit [DUR_W-1:0] mean;
        bit [DUR_W-1:0] lo;
        bit [DUR_W-1:0] hi;
    } t_stats;

    // The board keeps its own ring of samples, running sum and window register, works
    // out the statistics that each accepted beat must produce, and queues them in order.
    class t_scoreboard;
        bit [DUR_W-1:0] samples [DEPTH];
        int unsigned    newest;
        int unsigned    held;
        bit [SUM_W-1:0] total;
        bit [WIN_W-1:0] window;
        t_stats         expected_stats [$];
        int             errors;
        int             results_seen;

        function new();
            window       = WINDOW_RESET;
            errors       = 0;
            results_seen = 0;
            empty_ring();
        endfunction

        function void empty_ring();
            newest = 0;
            held   = 0;
            total  = '0;
        endfunction

        // A window write always empties the ring as well.
        function void set_window(bit [WIN_W-1:0] w);
            window = w;
            empty_ring();
        endfunction

        // A window of zero behaves as one, and anything above the depth as the depth.
        function int unsigned span();
            int unsigned w;
            w = window;
            if (w == 0) w = 1;
            if (w > DEPTH) w = DEPTH;
            return w;
        endfunction

        function void note_input(t_op op, bit [DUR_W-1:0] d);
            t_stats      want;
            int unsigned w;
            if (op == OP_CLEAR) begin
                empty_ring();
            end else begin
                w = span();
                if (held < w) begin
                    // Still filling: append behind the newest sample.
                    newest          = held;
                    samples[newest] = d;
                    held++;
                    total += d;
                end else begin
                    // Full: the slot after the newest holds the oldest sample.
                    newest          = (newest + 1) % w;
                    total           = total - samples[newest] + d;
                    samples[newest] = d;
                end
            end
            want = '0;
            if (held != 0) begin
                want.has   = 1'b1;
                want.count = CNT_W'(held);
                want.last  = samples[newest];
                want.mean  = DUR_W'(total / held);
                want.lo    = samples[0];
                want.hi    = samples[0];
                for (int unsigned i = 1; i < held; i++) begin
                    if (samples[i] < want.lo) want.lo = samples[i];
                    if (samples[i] > want.hi) want.hi = samples[i];
                end
            end
            expected_stats.insert(expected_stats.size(), want);
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        task report_mismatch(string what, longint unsigned want, longint unsigned got);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t: result %0d, %s: expected 0x%0h, got 0x%0h",
                         $realtime, results_seen, what, want, got);
        endtask

        task check_result(t_stats got);
            t_stats want;
            if (expected_stats.size() == 0) begin
                report_mismatch("result with nothing outstanding", 0, 0);
                return;
            end
            want = expected_stats.pop_front();
            if (got.has != want.has)     report_mismatch("has_samples", want.has, got.has);
            if (got.count != want.count) report_mismatch("sample_count", want.count, got.count);
            if (got.last != want.last)   report_mismatch("last_duration", want.last, got.last);
            if (got.mean != want.mean)   report_mismatch("mean_duration", want.mean, got.mean);
            if (got.lo != want.lo)       report_mismatch("min_duration", want.lo, got.lo);
            if (got.hi != want.hi)       report_mismatch("max_duration", want.hi, got.hi);
            results_seen++;
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [WIN_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_mode;
    logic [DUR_W-1:0] i_duration;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_has_samples;
    logic [CNT_W-1:0] o_sample_count;
    logic [DUR_W-1:0] o_last_duration;
    logic [DUR_W-1:0] o_mean_duration;
    logic [DUR_W-1:0] o_min_duration;
    logic [DUR_W-1:0] o_max_duration;

    t_scoreboard board;

    // Pacing shared by the sender and the receiver. When pace_idle is low both sides run
    // flat out; hold_req asks the receiver for one long stall, its length set by HOLD_CYCLES.
    bit pace_idle;
    bit hold_req;
    int burst_left;

    windowed_duration_statistics #(
        .DEPTH         (DEPTH),
        .DURATION_BITS (DUR_W)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_duration      (i_duration),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_has_samples   (o_has_samples),
        .o_sample_count  (o_sample_count),
        .o_last_duration (o_last_duration),
        .o_mean_duration (o_mean_duration),
        .o_min_duration  (o_min_duration),
        .o_max_duration  (o_max_duration)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The run should finish well inside this; reaching it means the block has hung.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result beats are taken at the rising edge at which valid and ready are both high.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result('{o_has_samples, o_sample_count, o_last_duration,
                                 o_mean_duration, o_min_duration, o_max_duration});
    end

    // The receiver. Outside idle phases it is always ready; inside them it alternates
    // ready and stalled runs of random length. A hold request overrides both, and the
    // stall is counted here so that the sender keeps offering beats meanwhile.
    initial begin : result_sink
        int hold_left;
        int run_left;
        bit run_ready;
        hold_left   = 0;
        run_left    = 0;
        run_ready   = 1'b1;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else if (!pace_idle) begin
                i_out_ready = 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_ready = !run_ready;
                    run_left  = run_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
                end
                run_left--;
                i_out_ready = run_ready;
            end
        end
    end

    // Durations lean towards the extremes and small values so that ties, the minimum and
    // maximum limits and sums far past 32 bits all turn up often.
    function automatic bit [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DUR_W'($urandom_range(0, 15)) | {1'b1, {(DUR_W-1){1'b0}}};
            3, 4:    return DUR_W'($urandom_range(0, 255));
            default: return DUR_W'($urandom);
        endcase
    endfunction

    // Offers one beat and returns at the falling edge after it was taken. Valid is left
    // high so that a following beat in the same burst goes out without a gap; whoever
    // stops sending lowers it. All tasks are entered and left at a falling edge.
    task automatic send_item(t_op op, bit [DUR_W-1:0] d);
        if (pace_idle) begin
            if (burst_left == 0) begin
                i_in_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
        end
        i_in_valid = 1'b1;
        i_mode     = op;
        i_duration = d;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(op, d);
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every outstanding result has arrived. Each beat
    // gives exactly one result, so the block is idle once the queue is empty.
    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_window(bit [WIN_W-1:0] w);
        wait_drain();
        i_cfg_we   = 1'b1;
        i_cfg_data = w;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.set_window(w);
    endtask

    // A random phase: mostly runs of records with occasional clears, at one window
    // setting. With squeeze set the receiver stalls for a long stretch early on.
    task automatic run_phase(bit [WIN_W-1:0] w, int beats, int clear_odds, bit idle,
                             bit squeeze);
        int k;
        write_window(w);
        pace_idle = idle;
        for (k = 0; k < beats; k++) begin
            if (squeeze && k == 2) hold_req = 1'b1;
            if ($urandom_range(1, clear_odds) == 1)
                send_item(OP_CLEAR, DUR_W'($urandom));
            else
                send_item(OP_RECORD, pick_duration());
        end
    endtask

    initial begin : stimulus
        int k;
        board      = new();
        pace_idle  = 1'b1;
        hold_req   = 1'b0;
        burst_left = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode     = OP_RECORD;
        i_duration = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed beats at the reset window: a clear on an empty store, then the
        // extremes of the duration field and alternating bit patterns.
        send_item(OP_CLEAR, '1);
        send_item(OP_RECORD, '0);
        send_item(OP_RECORD, '1);
        send_item(OP_RECORD, 32'h0000_0001);
        send_item(OP_RECORD, 32'h8000_0000);
        send_item(OP_RECORD, 32'h7FFF_FFFF);
        send_item(OP_RECORD, 32'h5555_5555);
        send_item(OP_RECORD, 32'hAAAA_AAAA);
        send_item(OP_CLEAR, '0);
        // Three maximal samples push the running sum beyond 32 bits.
        for (k = 0; k < 3; k++) send_item(OP_RECORD, '1);

        // A window of one: once the store holds a sample, every record replaces it.
        write_window(7'd1);
        send_item(OP_RECORD, 32'd5);
        send_item(OP_RECORD, 32'd9);
        send_item(OP_CLEAR, 32'd7);
        send_item(OP_RECORD, 32'd3);

        // A window of zero must behave as a window of one.
        write_window(7'd0);
        send_item(OP_RECORD, 32'd11);
        send_item(OP_RECORD, 32'd0);

        // A window above the depth must behave as the full depth.
        write_window(7'd127);
        send_item(OP_RECORD, '1);
        send_item(OP_RECORD, 32'd2);

        // A short window that wraps, so the oldest sample leaves the sum.
        write_window(7'd3);
        for (k = 1; k <= 5; k++) send_item(OP_RECORD, DUR_W'(k * 10));

        // Random phases. The long full-depth phases wrap the ring several times; the
        // phases without idling run back to back, with the receiver ready but for a squeeze stall.
        run_phase(7'd64, 200, 150, 1'b1, 1'b1);
        run_phase(7'd1, 50, 10, 1'b1, 1'b0);
        run_phase(7'd0, 30, 10, 1'b0, 1'b0);
        run_phase(7'd127, 150, 200, 1'b0, 1'b1);
        run_phase(7'd5, 60, 20, 1'b1, 1'b0);
        run_phase(7'd17, 60, 15, 1'b1, 1'b0);
        run_phase(7'd2, 40, 8, 1'b0, 1'b0);
        for (k = 0; k < 4; k++)
            run_phase(WIN_W'($urandom_range(0, 127)), 60, 25, 1'(k % 2), 1'b0);

        wait_drain();
        // Anything the block still produces after this would be an extra result.
        repeat (SETTLE) @(negedge i_clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
